// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tuner sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sequencer assertion failed");

// Check that a condition implies a property on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("sequencer assertion failed");

`endif

// ===== hw/rtl/atsks_pkg.sv =====
// ----------------------------------------------------------------------------
// atsks_pkg
// Types and constants shared by the antenna tuner start/key sequencer.
// ----------------------------------------------------------------------------
package atsks_pkg;

	// Configuration register width and index width
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Default timer width
	localparam int TIMER_BITS_DEF = 16;

	// Register reset values in milliseconds
	localparam logic [CFG_W-1:0] START_HOLD_RST  = 16'd600;
	localparam logic [CFG_W-1:0] KEY_LOW_TO_RST  = 16'd2000;
	localparam logic [CFG_W-1:0] TUNE_TO_RST     = 16'd20000;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_HOLD = 2'd0,
		CFG_KEY_LOW_TO = 2'd1,
		CFG_TUNE_TO    = 2'd2
	} cfg_idx_t;

	// Handshake phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HOLD    = 2'd1,
		PH_WAITLOW = 2'd2,
		PH_RF      = 2'd3
	} phase_t;

	// Status codes reported to the host
	typedef enum logic [2:0] {
		ST_DONE         = 3'd0,
		ST_RF_REQ       = 3'd1,
		ST_KEY_NOT_HIGH = 3'd2,
		ST_KEY_TIMEOUT  = 3'd3,
		ST_SAFETY       = 3'd4
	} status_t;

	// Timer limits handed from the register file to the core
	typedef struct packed {
		logic [CFG_W-1:0] start_hold_ms;
		logic [CFG_W-1:0] key_low_timeout_ms;
		logic [CFG_W-1:0] tune_timeout_ms;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic    start_drive;
		logic    status_write;
		status_t status_code;
		phase_t  phase;
	} result_t;

endpackage

// ===== hw/rtl/atsks_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// atsks_cfg_regs
// Timer limit registers behind the plain configuration write port.
// ----------------------------------------------------------------------------
module atsks_cfg_regs
	import atsks_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_hold_ms      <= START_HOLD_RST;
			cfg_q.key_low_timeout_ms <= KEY_LOW_TO_RST;
			cfg_q.tune_timeout_ms    <= TUNE_TO_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_START_HOLD: cfg_q.start_hold_ms      <= cfg_wdata;
				CFG_KEY_LOW_TO: cfg_q.key_low_timeout_ms <= cfg_wdata;
				CFG_TUNE_TO:    cfg_q.tune_timeout_ms    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/atsks_seq_core.sv =====
// ----------------------------------------------------------------------------
// atsks_seq_core
// Phase state machine and millisecond timer; one request per cycle while advance is high.
// ----------------------------------------------------------------------------
module atsks_seq_core
	import atsks_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    key_level,
	input  logic    tune_request,
	input  logic    ms_tick,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

	phase_t                phase_q, phase_nx;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_inc, elapsed_nx;
	logic                  start_q, start_nx;
	logic                  wr;
	status_t               code;
	logic                  exp_hold, exp_key, exp_tune;

	// Advance the timer by one tick, saturating at all ones
	assign elapsed_inc = (ms_tick && (elapsed_q != TMR_MAX)) ?
		elapsed_q + TIMER_BITS'(1) : elapsed_q;

	// Expire on reaching the limit or on a saturated timer
	function automatic logic expired(input logic [TIMER_BITS-1:0] el,
			input logic [CFG_W-1:0] limit);
		logic [CMP_W-1:0] el_w, lim_w;
		el_w  = CMP_W'(el);
		lim_w = CMP_W'(limit);
		return (el_w >= lim_w) || (el == TMR_MAX);
	endfunction

	assign exp_hold = expired(elapsed_inc, cfg.start_hold_ms);
	assign exp_key  = expired(elapsed_inc, cfg.key_low_timeout_ms);
	assign exp_tune = expired(elapsed_inc, cfg.tune_timeout_ms);

	// Hold phase, timer and start level between requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			start_q   <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_nx;
			elapsed_q <= elapsed_nx;
			start_q   <= start_nx;
		end
	end

	// Decide the next phase and the status report
	always_comb begin
		phase_nx   = phase_q;
		elapsed_nx = elapsed_inc;
		start_nx   = start_q;
		wr         = 1'b0;
		code       = ST_DONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (tune_request) begin
					if (!key_level) begin
						wr   = 1'b1;
						code = ST_KEY_NOT_HIGH;
					end else begin
						start_nx   = 1'b1;
						phase_nx   = PH_HOLD;
						elapsed_nx = '0;
					end
				end
			end
			PH_HOLD: begin
				if (exp_hold) begin
					start_nx   = 1'b0;
					phase_nx   = PH_WAITLOW;
					elapsed_nx = '0;
				end
			end
			PH_WAITLOW: begin
				if (!key_level) begin
					wr         = 1'b1;
					code       = ST_RF_REQ;
					phase_nx   = PH_RF;
					elapsed_nx = '0;
				end else if (exp_key) begin
					wr         = 1'b1;
					code       = ST_KEY_TIMEOUT;
					phase_nx   = PH_IDLE;
					elapsed_nx = '0;
				end
			end
			PH_RF: begin
				if (key_level) begin
					wr         = 1'b1;
					code       = ST_DONE;
					phase_nx   = PH_IDLE;
					elapsed_nx = '0;
				end else if (exp_tune) begin
					wr         = 1'b1;
					code       = ST_SAFETY;
					phase_nx   = PH_IDLE;
					elapsed_nx = '0;
				end
			end
			default: begin
				phase_nx = PH_IDLE;
			end
		endcase
	end

	assign result.start_drive  = start_nx;
	assign result.status_write = wr;
	assign result.status_code  = code;
	assign result.phase        = phase_nx;

endmodule

// ===== hw/rtl/atsks_out_reg.sv =====
// ----------------------------------------------------------------------------
// atsks_out_reg
// Result register on the output channel; holds a request while stalled.
// ----------------------------------------------------------------------------
module atsks_out_reg
	import atsks_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;

	// Keep a result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & out_stall);
		end
	end

	// Load the payload when a new result comes in
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

// ===== hw/rtl/antenna_tuner_start_key_sequencer.sv =====
// ----------------------------------------------------------------------------
// antenna_tuner_start_key_sequencer
// Start/key handshake sequencer for an external antenna tuner.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one poll sample per
//   request: key_level, tune_request and ms_tick. The output channel
//   (out_valid / out_stall) returns exactly one result per sample: the start
//   line level, a status write strobe with its code, and the phase.
//   A sample is taken into the input register, passes the combinational phase
//   logic and lands in the result register, where out_valid rises and the
//   receiver can take it. One sample is accepted every cycle while the
//   receiver does not stall; the rate is set by the phase update between the
//   two registers. When the receiver stalls, the result register holds its
//   request and the input register fills; in_stall then rises until the
//   result is taken. Reset clears both registers, puts the sequencer in idle
//   with the start line released and the timer at zero, and loads the default
//   limits (600 ms hold, 2000 ms key low, 20000 ms tune). The user writes the
//   limits on cfg_we / cfg_addr / cfg_wdata only while no sample is in
//   flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module antenna_tuner_start_key_sequencer
	import atsks_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 key_level,
	input  logic                 tune_request,
	input  logic                 ms_tick,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 start_drive,
	output logic                 status_write,
	output logic [2:0]           status_code,
	output logic [1:0]           phase
);

	cfg_t    cfg;
	result_t result, out_result;
	logic    valid_s1, key_s1, req_s1, tick_s1;
	logic    advance, take_in;

	atsks_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move the sampled request on when the result register is free
	assign advance  = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign take_in  = in_valid & ~in_stall;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take_in | (valid_s1 & ~advance);
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			key_s1  <= key_level;
			req_s1  <= tune_request;
			tick_s1 <= ms_tick;
		end
	end

	atsks_seq_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.key_level    (key_s1),
		.tune_request (req_s1),
		.ms_tick      (tick_s1),
		.cfg          (cfg),
		.result       (result)
	);

	atsks_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.result     (result),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_result (out_result)
	);

	assign start_drive  = out_result.start_drive;
	assign status_write = out_result.status_write;
	assign status_code  = out_result.status_code;
	assign phase        = out_result.phase;

endmodule

// ===== hw/rtl/atsks_checker.sv =====
// ----------------------------------------------------------------------------
// atsks_checker
// Port-level assertions for the tuner sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atsks_checker
	import atsks_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       start_drive,
	input logic       status_write,
	input logic [2:0] status_code,
	input logic [1:0] phase
);

	// A stalled result holds its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({start_drive, status_write, status_code, phase}))

	// Start is driven exactly while the start-held phase is reported
	`ASSERT_CLK(a_start_phase, clk, arst_n, out_valid |-> (start_drive == (phase == PH_HOLD)))

	// Without a status write the code reads as done
	`ASSERT_CLK(a_code_quiet, clk, arst_n, (out_valid && !status_write) |-> (status_code == ST_DONE))

	// An RF request lands in the RF active phase
	`ASSERT_CLK(a_rf_req_phase, clk, arst_n, (out_valid && status_write && (status_code == ST_RF_REQ)) |-> (phase == PH_RF))

	// Every other status report returns to idle
	`ASSERT_CLK(a_report_idle, clk, arst_n, (out_valid && status_write && (status_code != ST_RF_REQ)) |-> (phase == PH_IDLE))

endmodule

bind antenna_tuner_start_key_sequencer atsks_checker u_atsks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.start_drive  (start_drive),
	.status_write (status_write),
	.status_code  (status_code),
	.phase        (phase)
);

// ===== sim/tuner_seq_checker.sv =====
// ----------------------------------------------------------------------------
// tuner_seq_checker
// Scoreboard for the antenna tuner start/key sequencer: mirrors the limit
// registers, predicts one result per accepted poll request and compares every
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuner_seq_checker
	import atsks_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 key_level,
	input  logic                 tune_request,
	input  logic                 ms_tick,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 start_drive,
	input  logic                 status_write,
	input  logic [2:0]           status_code,
	input  logic [1:0]           phase,
	output int                   fail_count,
	output int                   pending
);

	// Mirrored limits and sequencer state
	logic [CFG_W-1:0]      hold_lim;
	logic [CFG_W-1:0]      key_low_lim;
	logic [CFG_W-1:0]      tune_lim;
	phase_t                seq_phase;
	logic [TIMER_BITS-1:0] seq_elapsed;
	logic                  seq_start;
	result_t               awaited_results[$];

	// A phase timer runs out at its limit or when the counter is pinned
	function automatic logic limit_reached(logic [TIMER_BITS-1:0] ms, logic [CFG_W-1:0] lim);
		return (ms >= lim) || (ms == {TIMER_BITS{1'b1}});
	endfunction

	// Advance the mirrored sequencer by one poll sample
	task automatic predict_tuner_result(input logic key, input logic req, input logic tick,
			output result_t res);
		logic    wr;
		status_t code;
		wr = 1'b0;
		code = ST_DONE;
		if (tick && seq_elapsed != {TIMER_BITS{1'b1}})
			seq_elapsed = seq_elapsed + 1'b1;
		case (seq_phase)
			PH_IDLE: begin
				if (req) begin
					if (!key) begin
						wr = 1'b1;
						code = ST_KEY_NOT_HIGH;
					end else begin
						seq_start = 1'b1;
						seq_phase = PH_HOLD;
						seq_elapsed = '0;
					end
				end
			end
			PH_HOLD: begin
				if (limit_reached(seq_elapsed, hold_lim)) begin
					seq_start = 1'b0;
					seq_phase = PH_WAITLOW;
					seq_elapsed = '0;
				end
			end
			PH_WAITLOW: begin
				if (!key) begin
					wr = 1'b1;
					code = ST_RF_REQ;
					seq_phase = PH_RF;
					seq_elapsed = '0;
				end else if (limit_reached(seq_elapsed, key_low_lim)) begin
					wr = 1'b1;
					code = ST_KEY_TIMEOUT;
					seq_phase = PH_IDLE;
					seq_elapsed = '0;
				end
			end
			default: begin
				if (key) begin
					wr = 1'b1;
					code = ST_DONE;
					seq_phase = PH_IDLE;
					seq_elapsed = '0;
				end else if (limit_reached(seq_elapsed, tune_lim)) begin
					wr = 1'b1;
					code = ST_SAFETY;
					seq_phase = PH_IDLE;
					seq_elapsed = '0;
				end
			end
		endcase
		res.start_drive = seq_start;
		res.status_write = wr;
		res.status_code = code;
		res.phase = seq_phase;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			hold_lim = START_HOLD_RST;
			key_low_lim = KEY_LOW_TO_RST;
			tune_lim = TUNE_TO_RST;
			seq_phase = PH_IDLE;
			seq_elapsed = '0;
			seq_start = 1'b0;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Track limit writes; the spare index is dropped
			if (cfg_we) begin
				case (cfg_addr)
					CFG_START_HOLD: hold_lim = cfg_wdata;
					CFG_KEY_LOW_TO: key_low_lim = cfg_wdata;
					CFG_TUNE_TO:    tune_lim = cfg_wdata;
					default: ;
				endcase
			end

			// Compare a taken result with the oldest prediction
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					got.start_drive = start_drive;
					got.status_write = status_write;
					got.status_code = status_t'(status_code);
					got.phase = phase_t'(phase);
					if (got.start_drive !== want.start_drive) begin
						$error("start_drive: expected %0d, got %0d",
							want.start_drive, start_drive);
						fail_count++;
					end
					if (got.status_write !== want.status_write) begin
						$error("status_write: expected %0d, got %0d",
							want.status_write, status_write);
						fail_count++;
					end
					if (status_code !== 3'(want.status_code)) begin
						$error("status_code: expected %0d, got %0d",
							want.status_code, status_code);
						fail_count++;
					end
					if (phase !== 2'(want.phase)) begin
						$error("phase: expected %0d, got %0d", want.phase, phase);
						fail_count++;
					end
				end
			end

			// Predict the result of a taken request
			if (in_valid && !in_stall) begin
				predict_tuner_result(key_level, tune_request, ms_tick, want);
				awaited_results.push_back(want);
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the antenna tuner start/key sequencer. Runs a
// scripted walk through every phase and status code, a pass with all limits
// at zero, randomized tune sessions under several limit settings with bursty
// requests and back-pressure, and one short session with all limits at their
// maximum so the start line stays held while the timer runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import atsks_pkg::*;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [CFG_W-1:0]     LIM_MAX   = 16'hFFFF;

	// Scripted walk, {key, request, tick}, with limits 2 / 3 / 3
	localparam logic [2:0] WALK [27] = '{
		3'b100, 3'b001,                 // idle, no request
		3'b010, 3'b011,                 // request with key low
		3'b111,                         // start
		3'b011, 3'b100, 3'b101,         // hold, request ignored, release
		3'b111, 3'b101, 3'b001,         // key low and timeout together
		3'b011, 3'b001, 3'b101,         // key high and timeout together
		3'b110, 3'b101, 3'b101,         // start, release
		3'b101, 3'b101, 3'b101,         // key never drops
		3'b110, 3'b101, 3'b101,         // start, release
		3'b000,                         // key low
		3'b001, 3'b001, 3'b001          // key stays low past the limit
	};

	// Receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 key_level = 1'b0;
	logic                 tune_request = 1'b0;
	logic                 ms_tick = 1'b0;
	logic                 out_stall = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 start_drive;
	logic                 status_write;
	logic [2:0]           status_code;
	logic [1:0]           phase;
	int                   fail_count;
	int                   pending;

	// Sender pacing and stimulus shaping
	int gap_max = 3;
	int burst_left = 0;
	int sent = 0;
	int holdoff_reqs = 0;
	int hold_ms = 2;
	int key_ms = 3;
	int tune_ms = 3;

	antenna_tuner_start_key_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_level    (key_level),
		.tune_request (tune_request),
		.ms_tick      (ms_tick),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_drive  (start_drive),
		.status_write (status_write),
		.status_code  (status_code),
		.phase        (phase)
	);

	tuner_seq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_level    (key_level),
		.tune_request (tune_request),
		.ms_tick      (ms_tick),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_drive  (start_drive),
		.status_write (status_write),
		.status_code  (status_code),
		.phase        (phase),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#10_000_000;
		$display("antenna_tuner_start_key_sequencer regression: fail");
		$finish;
	end

	// Stall the result side on a pattern of its own, with long hold-offs on demand
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       holdoff_seen;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		holdoff_seen = 0;
		forever begin
			@(negedge clk);
			if (holdoff_seen != holdoff_reqs) begin
				holdoff_seen = holdoff_reqs;
				hold_left = $urandom_range(80, 40);
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(2, 0));
				mode_left = $urandom_range(256, 32);
			end
			mode_left--;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case (mode)
					RX_OPEN:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(99, 0) < 25);
					default:  out_stall <= ($urandom_range(99, 0) < 60);
				endcase
			end
		end
	end

	// Offer one poll request, in bursts with random gaps, and wait until taken
	task automatic put_sample(input logic k, input logic r, input logic t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(16, 1);
			if (gap_max > 0) begin
				gap = $urandom_range(gap_max, 1);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		key_level <= k;
		tune_request <= r;
		ms_tick <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Drop valid and wait until every result is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input int h, input int k, input int t);
		hold_ms = h;
		key_ms = k;
		tune_ms = t;
		write_reg(CFG_START_HOLD, CFG_W'(h));
		write_reg(CFG_KEY_LOW_TO, CFG_W'(k));
		write_reg(CFG_TUNE_TO, CFG_W'(t));
	endtask

	// One tune session with random content, or a stretch of noise
	task automatic tune_session();
		int   n;
		int   i;
		logic key_ok;
		if ($urandom_range(4, 0) == 0) begin
			n = $urandom_range(10, 4);
			for (i = 0; i < n; i++)
				put_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
					1'($urandom_range(1, 0)));
			return;
		end
		n = $urandom_range(3, 0);
		for (i = 0; i < n; i++)
			put_sample(1'($urandom_range(1, 0)), 1'b0, 1'($urandom_range(1, 0)));
		// Request, mostly with the key high
		key_ok = ($urandom_range(9, 0) != 0);
		put_sample(key_ok, 1'b1, 1'($urandom_range(1, 0)));
		if (!key_ok)
			return;
		// Hold: key and request do not matter
		n = hold_ms + $urandom_range(2, 0);
		for (i = 0; i < n; i++)
			put_sample(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
				$urandom_range(9, 0) < 8);
		// Wait for key low, sometimes past the limit
		n = $urandom_range(key_ms + 1, 0);
		for (i = 0; i < n; i++)
			put_sample(1'b1, 1'($urandom_range(1, 0)), $urandom_range(9, 0) < 7);
		put_sample(1'b0, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
		// RF active until key high or the safety limit
		n = $urandom_range(tune_ms + 1, 0);
		for (i = 0; i < n; i++)
			put_sample(1'b0, 1'($urandom_range(1, 0)), $urandom_range(9, 0) < 7);
		put_sample(1'b1, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
	endtask

	initial begin : stimulus
		int i;
		int round;
		int goal;
		logic pressed;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Scripted walk through every phase and code
		set_limits(2, 3, 3);
		for (i = 0; i < 27; i++)
			put_sample(WALK[i][2], WALK[i][1], WALK[i][0]);
		drain();

		// Zero limits expire on the first sample of each phase
		set_limits(0, 0, 0);
		put_sample(1'b1, 1'b1, 1'b0);
		put_sample(1'b0, 1'b0, 1'b0);
		put_sample(1'b1, 1'b0, 1'b0);
		put_sample(1'b1, 1'b1, 1'b0);
		put_sample(1'b1, 1'b0, 1'b0);
		put_sample(1'b0, 1'b0, 1'b0);
		put_sample(1'b0, 1'b0, 1'b0);
		drain();

		// Random sessions under several settings
		for (round = 0; round < 4; round++) begin
			case (round)
				0: begin
					set_limits(1, 1, 1);
					gap_max = 0;
				end
				1: begin
					set_limits($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1));
					gap_max = 3;
				end
				2: begin
					set_limits($urandom_range(8, 2), $urandom_range(8, 2), $urandom_range(8, 2));
					gap_max = 8;
				end
				default: begin
					write_reg(CFG_SPARE, CFG_W'($urandom));
					set_limits($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1));
					gap_max = 2;
				end
			endcase
			goal = sent + 95;
			pressed = 1'b0;
			while (sent < goal) begin
				// Hold off the receiver while requests keep coming
				if (round == 1 && !pressed && sent > goal - 60) begin
					holdoff_reqs++;
					pressed = 1'b1;
				end
				tune_session();
			end
			drain();
		end

		// Limits at maximum: the start line stays held while the timer runs
		set_limits(LIM_MAX, LIM_MAX, LIM_MAX);
		gap_max = 0;
		put_sample(1'b1, 1'b1, 1'b0);
		repeat (12) put_sample(1'b1, 1'b0, 1'b1);
		put_sample(1'b0, 1'b1, 1'b1);
		drain();

		if (fail_count == 0) begin
			$display("antenna_tuner_start_key_sequencer regression: pass");
		end else begin
			$display("antenna_tuner_start_key_sequencer regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/atsks_pkg.sv
hw/rtl/atsks_cfg_regs.sv
hw/rtl/atsks_seq_core.sv
hw/rtl/atsks_out_reg.sv
hw/rtl/antenna_tuner_start_key_sequencer.sv
hw/rtl/atsks_checker.sv
sim/tuner_seq_checker.sv
sim/testbench.sv
